// ----- sv/tpsc_pkg.sv -----
// Shared types and constants for the tanh soft clipper.
`default_nettype none
package tpsc_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned QuoW    = 23;
  localparam int unsigned RemW    = 64;
  localparam int unsigned DenW    = 42;

  // Polynomial coefficients
  localparam logic [63:0] CN0 = 64'd378;
  localparam logic [63:0] CN1 = 64'd17325;
  localparam logic [63:0] CN2 = 64'd135135;
  localparam logic [63:0] CD0 = 64'd28;
  localparam logic [63:0] CD1 = 64'd3150;
  localparam logic [63:0] CD2 = 64'd62370;
  localparam logic [63:0] CD3 = 64'd135135;

  localparam logic [QuoW-1:0] OneQ22 = 23'd4194304;

  // One item travelling along the divider chain
  typedef struct packed {
    logic            vld;
    logic            neg;
    logic [RemW-1:0] rem;
    logic [DenW-1:0] den;
    logic [QuoW-1:0] quo;
  } div_t;

endpackage
`default_nettype wire

// ----- sv/tpsc_poly.sv -----
// Front end: magnitude, x squared, both Horner polynomials and the divider operands.
`default_nettype none
module tpsc_poly
  import tpsc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               vld_i,
  input  wire logic [SampleW-1:0] sample_i,
  output div_t                    div_o
);

  logic [9:0]  vld_q;
  logic        neg1_q, neg2_q, neg3_q, neg4_q, neg5_q, neg6_q, neg7_q, neg8_q, neg9_q;
  logic [23:0] a1_q, a2_q, a3_q, a4_q, a5_q, a6_q, a7_q;
  logic [47:0] x2_q;
  logic [22:0] t3_q, t4_q, t5_q, t6_q, t7_q;
  logic [47:0] pn1_q;
  logic [28:0] d1_4_q, d1_5_q;
  logic [31:0] n1_q;
  logic [54:0] pn2_q;
  logic [51:0] pd2_q;
  logic [37:0] n2_q;
  logic [34:0] d2_q;
  logic [40:0] pl_q;
  logic [39:0] ph_q;
  logic [42:0] ml_q, mh_q;
  logic [40:0] d3_q;
  logic [61:0] num_q;
  logic [RemW-1:0] rem_q;
  logic [DenW-1:0] den_q;
  logic            neg10_q;

  logic [24:0] n0;
  logic [63:0] t_w, d1_w, n1_w, n2_w, d2_w, d3_w, num_w, x2r_w;

  // Combinational helpers for each stage
  always_comb begin
    x2r_w = 64'(x2_q) + 64'd8388608;
    t_w   = x2r_w >> 24;
    n0    = 25'((CN0 << 16) + 64'(t3_q));
    d1_w  = (CD1 << 16) + 64'(t3_q) * CD0;
    n1_w  = (CN1 << 16) + (64'(pn1_q) >> 16);
    n2_w  = (CN2 << 16) + (64'(pn2_q) >> 16);
    d2_w  = (CD2 << 16) + (64'(pd2_q) >> 16);
    d3_w  = (CD3 << 16) + (((64'(ph_q) << 18) + 64'(pl_q)) >> 16);
    num_w = (64'(mh_q) << 19) + 64'(ml_q);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[8:0], vld_i};
    end
  end

  // Payload pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q  <= sample_i[SampleW-1];
      a1_q    <= sample_i[SampleW-1] ? 24'(-sample_i) : sample_i;
      x2_q    <= 48'(a1_q) * 48'(a1_q);
      a2_q    <= a1_q;  neg2_q <= neg1_q;
      t3_q    <= t_w[22:0];
      a3_q    <= a2_q;  neg3_q <= neg2_q;
      pn1_q   <= 48'(t3_q) * 48'(n0);
      d1_4_q  <= d1_w[28:0];
      t4_q    <= t3_q;  a4_q <= a3_q;  neg4_q <= neg3_q;
      n1_q    <= n1_w[31:0];
      d1_5_q  <= d1_4_q;
      t5_q    <= t4_q;  a5_q <= a4_q;  neg5_q <= neg4_q;
      pn2_q   <= 55'(t5_q) * 55'(n1_q);
      pd2_q   <= 52'(t5_q) * 52'(d1_5_q);
      t6_q    <= t5_q;  a6_q <= a5_q;  neg6_q <= neg5_q;
      n2_q    <= n2_w[37:0];
      d2_q    <= d2_w[34:0];
      t7_q    <= t6_q;  a7_q <= a6_q;  neg7_q <= neg6_q;
      // wide products split in halves
      pl_q    <= 41'(t7_q) * 41'(d2_q[17:0]);
      ph_q    <= 40'(t7_q) * 40'(d2_q[34:18]);
      ml_q    <= 43'(a7_q) * 43'(n2_q[18:0]);
      mh_q    <= 43'(a7_q) * 43'(n2_q[37:19]);
      neg8_q  <= neg7_q;
      d3_q    <= d3_w[40:0];
      num_q   <= num_w[61:0];
      neg9_q  <= neg8_q;
      // dividend 8*num + d over divisor 2*d
      rem_q   <= (64'(num_q) << 3) + 64'(d3_q);
      den_q   <= {d3_q, 1'b0};
      neg10_q <= neg9_q;
    end
  end

  always_comb begin
    div_o     = '0;
    div_o.vld = vld_q[9];
    div_o.neg = neg10_q;
    div_o.rem = rem_q;
    div_o.den = den_q;
  end

endmodule
`default_nettype wire

// ----- sv/tpsc_div_cell.sv -----
// One restoring-division cell: settles a single quotient bit.
`default_nettype none
module tpsc_div_cell
  import tpsc_pkg::*;
#(
  parameter int unsigned Bit = 0
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire div_t div_i,
  output div_t      div_o
);

  logic [RemW:0]   dsh, diff;
  logic            ge;
  logic            vld_q;
  div_t            pay_d, pay_q;

  // Trial subtract of the shifted divisor
  always_comb begin
    dsh  = (RemW+1)'(div_i.den) << Bit;
    diff = {1'b0, div_i.rem} - dsh;
    ge   = !diff[RemW];
  end

  // Keep the remainder if it fits, note the quotient bit
  always_comb begin
    pay_d          = div_i;
    pay_d.rem      = ge ? diff[RemW-1:0] : div_i.rem;
    pay_d.quo[Bit] = ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= div_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q <= pay_d;
    end
  end

  always_comb begin
    div_o     = pay_q;
    div_o.vld = vld_q;
  end

endmodule
`default_nettype wire

// ----- sv/tanh_pade_soft_clipper_top.sv -----
// Pade (7,6) tanh soft clipper: 10-stage polynomial front end, 23-cell divider.
// Throughput: one sample per cycle; the whole pipeline holds only while a
// result waits on the output and out_stall_i is high.
// Reset: rst_ni asynchronous, active low, clears all valid bits; data
// registers are not reset.
`default_nettype none
module tanh_pade_soft_clipper_top
  import tpsc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [SampleW-1:0] sample_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [SampleW-1:0]      clipped_o
);

  logic                en;
  logic                out_vld_q;
  logic [SampleW-1:0]  clipped_q;
  logic [QuoW-1:0]     qsat;
  div_t                chain [QuoW+1];

  // Pipeline moves whenever the output register can take a transfer
  assign en         = !out_vld_q || !out_stall_i;
  assign in_stall_o = !en;

  tpsc_poly u_poly (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (in_valid_i),
    .sample_i (sample_i),
    .div_o    (chain[0])
  );

  // Divider chain, most significant quotient bit first
  for (genvar i = 0; i < QuoW; i++) begin : g_cell
    tpsc_div_cell #(.Bit(QuoW-1-i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .div_i  (chain[i]),
      .div_o  (chain[i+1])
    );
  end

  // Saturate to one and restore the sign
  assign qsat = (chain[QuoW].quo > OneQ22) ? OneQ22 : chain[QuoW].quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= chain[QuoW].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      clipped_q <= chain[QuoW].neg ? SampleW'(-{1'b0, qsat}) : {1'b0, qsat};
    end
  end

  assign out_valid_o = out_vld_q;
  assign clipped_o   = clipped_q;

endmodule
`default_nettype wire
